FILE: rtl/rsp_pkg.sv
// Shared types, constants and symbol tables for the random symbol picker.
`timescale 1ns / 1ps

package rsp_pkg;

    localparam int WORD_W   = 32;
    localparam int SYM_W    = 7;
    localparam int LEN_W    = 10;
    localparam int ALPHA_W  = 7;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int BIT_CNT_W  = 5;

    localparam logic [WORD_W-1:0] WORD_MAX = 32'hFFFF_FFFF;

    localparam logic [ALPHA_W-1:0] LOWER_N   = 7'd26;
    localparam logic [ALPHA_W-1:0] UPPER_N   = 7'd26;
    localparam logic [ALPHA_W-1:0] DIGIT_N   = 7'd10;
    localparam logic [ALPHA_W-1:0] SPECIAL_N = 7'd24;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_LOWER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIGIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPECIAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_CLASS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_LEN_ZERO = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_EMIT,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic load;      // capture the incoming word
        logic step;      // one remainder step
        logic emit_ok;   // load a symbol result
        logic emit_err;  // load an error result
    } dp_cmd_t;

    typedef struct packed {
        logic len_zero;
        logic no_class;
        logic reject;
        logic div_last;
    } dp_status_t;

    // Enable bits ordered {special, digit, upper, lower}
    function automatic logic [ALPHA_W-1:0] alpha_size(input logic [3:0] en);
        logic [ALPHA_W-1:0] n;
        n = '0;
        if (en[0]) n = n + LOWER_N;
        if (en[1]) n = n + UPPER_N;
        if (en[2]) n = n + DIGIT_N;
        if (en[3]) n = n + SPECIAL_N;
        return n;
    endfunction

    // WORD_MAX mod n for every non-empty class mix, folded at elaboration
    function automatic logic [ALPHA_W-1:0] max_mod(input logic [3:0] en);
        logic [ALPHA_W-1:0] r;
        case (en)
            4'b0001: r = 7'(WORD_MAX % 26);
            4'b0010: r = 7'(WORD_MAX % 26);
            4'b0011: r = 7'(WORD_MAX % 52);
            4'b0100: r = 7'(WORD_MAX % 10);
            4'b0101: r = 7'(WORD_MAX % 36);
            4'b0110: r = 7'(WORD_MAX % 36);
            4'b0111: r = 7'(WORD_MAX % 62);
            4'b1000: r = 7'(WORD_MAX % 24);
            4'b1001: r = 7'(WORD_MAX % 50);
            4'b1010: r = 7'(WORD_MAX % 50);
            4'b1011: r = 7'(WORD_MAX % 76);
            4'b1100: r = 7'(WORD_MAX % 34);
            4'b1101: r = 7'(WORD_MAX % 60);
            4'b1110: r = 7'(WORD_MAX % 60);
            4'b1111: r = 7'(WORD_MAX % 86);
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [SYM_W-1:0] lower_sym(input logic [4:0] i);
        logic [SYM_W-1:0] s;
        case (i)
            5'd0:  s = 7'h61; 5'd1:  s = 7'h7A; 5'd2:  s = 7'h65; 5'd3:  s = 7'h72;
            5'd4:  s = 7'h74; 5'd5:  s = 7'h79; 5'd6:  s = 7'h75; 5'd7:  s = 7'h69;
            5'd8:  s = 7'h6F; 5'd9:  s = 7'h70; 5'd10: s = 7'h71; 5'd11: s = 7'h73;
            5'd12: s = 7'h64; 5'd13: s = 7'h66; 5'd14: s = 7'h67; 5'd15: s = 7'h68;
            5'd16: s = 7'h6A; 5'd17: s = 7'h6B; 5'd18: s = 7'h6C; 5'd19: s = 7'h6D;
            5'd20: s = 7'h77; 5'd21: s = 7'h78; 5'd22: s = 7'h63; 5'd23: s = 7'h76;
            5'd24: s = 7'h62; 5'd25: s = 7'h6E;
            default: s = '0;
        endcase
        return s;
    endfunction

    // Upper-case table follows the lower-case order with bit 5 cleared
    function automatic logic [SYM_W-1:0] upper_sym(input logic [4:0] i);
        return lower_sym(i) & 7'h5F;
    endfunction

    function automatic logic [SYM_W-1:0] digit_sym(input logic [3:0] i);
        logic [SYM_W-1:0] s;
        case (i)
            4'd0: s = 7'h31; 4'd1: s = 7'h32; 4'd2: s = 7'h33; 4'd3: s = 7'h34;
            4'd4: s = 7'h35; 4'd5: s = 7'h36; 4'd6: s = 7'h37; 4'd7: s = 7'h38;
            4'd8: s = 7'h39; 4'd9: s = 7'h30;
            default: s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [SYM_W-1:0] special_sym(input logic [4:0] i);
        logic [SYM_W-1:0] s;
        case (i)
            5'd0:  s = 7'h5B; 5'd1:  s = 7'h5D; 5'd2:  s = 7'h28; 5'd3:  s = 7'h29;
            5'd4:  s = 7'h7B; 5'd5:  s = 7'h7D; 5'd6:  s = 7'h2E; 5'd7:  s = 7'h3F;
            5'd8:  s = 7'h21; 5'd9:  s = 7'h2C; 5'd10: s = 7'h3A; 5'd11: s = 7'h3B;
            5'd12: s = 7'h2F; 5'd13: s = 7'h5C; 5'd14: s = 7'h7C; 5'd15: s = 7'h2D;
            5'd16: s = 7'h7E; 5'd17: s = 7'h23; 5'd18: s = 7'h26; 5'd19: s = 7'h3D;
            5'd20: s = 7'h5E; 5'd21: s = 7'h24; 5'd22: s = 7'h25; 5'd23: s = 7'h2A;
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/rsp_datapath.sv
// Datapath: configuration registers, bit-serial remainder, symbol lookup, result register.
`timescale 1ns / 1ps

module rsp_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rsp_pkg::dp_cmd_t                    cmd,
    output rsp_pkg::dp_status_t                 status,
    input  logic [rsp_pkg::WORD_W-1:0]          word_in,
    input  logic                                cfg_write,
    input  logic [rsp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rsp_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic [rsp_pkg::SYM_W-1:0]           symbol,
    output logic                                last,
    output logic [rsp_pkg::STATUS_W-1:0]        result_status
);
    import rsp_pkg::*;

    logic [3:0]          enable_reg;
    logic [LEN_W-1:0]    length_reg;
    logic [LEN_W-1:0]    count_reg, count_next;
    logic [WORD_W-1:0]   word_reg;
    logic [WORD_W-1:0]   shift_reg, shift_next;
    logic [ALPHA_W-1:0]  rem_reg, rem_next;
    logic [BIT_CNT_W-1:0] bit_reg, bit_next;
    logic [SYM_W-1:0]    symbol_reg, symbol_next;
    logic                last_reg, last_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic [ALPHA_W-1:0]  alpha_n;
    logic [WORD_W-1:0]   limit;
    logic [ALPHA_W:0]    trial;
    logic [ALPHA_W:0]    trial_diff;
    logic [SYM_W-1:0]    pick;
    logic [ALPHA_W-1:0]  offset;
    logic                found;
    logic [LEN_W-1:0]    count_inc;
    logic                count_last;

    assign alpha_n = alpha_size(enable_reg);
    assign limit   = WORD_MAX - {{(WORD_W-ALPHA_W){1'b0}}, max_mod(enable_reg)};

    assign status.len_zero = (length_reg == '0);
    assign status.no_class = (enable_reg == '0);
    assign status.reject   = (word_reg >= limit);
    assign status.div_last = (bit_reg == '1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 4'b0111;
            length_reg <= LEN_W'(16);
        end else if (cfg_write) begin
            case (cfg_index)
                REG_LOWER:   enable_reg[0] <= cfg_data[0];
                REG_UPPER:   enable_reg[1] <= cfg_data[0];
                REG_DIGIT:   enable_reg[2] <= cfg_data[0];
                REG_SPECIAL: enable_reg[3] <= cfg_data[0];
                REG_LENGTH:  length_reg    <= cfg_data[LEN_W-1:0];
                default:     ;
            endcase
        end
    end

    // Restoring remainder, one dividend bit per step, MSB first
    assign trial      = {rem_reg, shift_reg[WORD_W-1]};
    assign trial_diff = trial - {1'b0, alpha_n};

    always_comb begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        if (cmd.load) begin
            shift_next = word_in;
            rem_next   = '0;
            bit_next   = '0;
        end else if (cmd.step) begin
            shift_next = {shift_reg[WORD_W-2:0], 1'b0};
            rem_next   = (trial >= {1'b0, alpha_n}) ? trial_diff[ALPHA_W-1:0]
                                                     : trial[ALPHA_W-1:0];
            bit_next   = bit_reg + 1'b1;
        end
    end

    // Walk the enabled classes in order to map the remainder to a symbol
    always_comb begin
        offset = rem_reg;
        found  = 1'b0;
        pick   = '0;
        if (enable_reg[0]) begin
            if (offset < LOWER_N) begin
                pick  = lower_sym(offset[4:0]);
                found = 1'b1;
            end else begin
                offset = offset - LOWER_N;
            end
        end
        if (enable_reg[1] && !found) begin
            if (offset < UPPER_N) begin
                pick  = upper_sym(offset[4:0]);
                found = 1'b1;
            end else begin
                offset = offset - UPPER_N;
            end
        end
        if (enable_reg[2] && !found) begin
            if (offset < DIGIT_N) begin
                pick  = digit_sym(offset[3:0]);
                found = 1'b1;
            end else begin
                offset = offset - DIGIT_N;
            end
        end
        if (enable_reg[3] && !found) begin
            pick = special_sym(offset[4:0]);
        end
    end

    assign count_inc  = count_reg + 1'b1;
    assign count_last = (count_inc >= length_reg) || (count_inc == '0);

    always_comb begin
        count_next  = count_reg;
        symbol_next = symbol_reg;
        last_next   = last_reg;
        status_next = status_reg;
        if (cmd.emit_err) begin
            count_next  = '0;
            symbol_next = '0;
            last_next   = 1'b1;
            status_next = status.len_zero ? STATUS_LEN_ZERO : STATUS_NO_CLASS;
        end else if (cmd.emit_ok) begin
            count_next  = count_last ? '0 : count_inc;
            symbol_next = pick;
            last_next   = count_last;
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            word_reg <= word_in;
        end
        shift_reg  <= shift_next;
        rem_reg    <= rem_next;
        bit_reg    <= bit_next;
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    assign symbol        = symbol_reg;
    assign last          = last_reg;
    assign result_status = status_reg;

endmodule

FILE: rtl/rsp_controller.sv
// Controller: sequences accept, check, remainder steps, result load and output hold.
`timescale 1ns / 1ps

module rsp_controller (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output rsp_pkg::dp_cmd_t      cmd,
    input  rsp_pkg::dp_status_t   status
);
    import rsp_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.len_zero || status.no_class) begin
                    state_next = ST_HOLD;
                end else if (status.reject) begin
                    // drop the word, no result
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (status.div_last) state_next = ST_EMIT;
            end
            ST_EMIT: state_next = ST_HOLD;
            ST_HOLD: begin
                if (m_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_CHECK: begin
                cmd.emit_err = status.len_zero || status.no_class;
            end
            ST_DIVIDE: cmd.step    = 1'b1;
            ST_EMIT:   cmd.emit_ok = 1'b1;
            ST_HOLD:   m_tvalid    = 1'b1;
            default:   ;
        endcase
    end

endmodule

FILE: rtl/random_symbol_picker.sv
// Top level of the random symbol picker: stream ports and configuration port.
`timescale 1ns / 1ps

// Turns 32-bit random words into password characters without modulo bias.
// Each accepted word is checked against the rejection limit for the current
// alphabet; a rejected word produces nothing and the picker returns to idle
// for the next word. A usable word runs through a bit-serial remainder unit,
// one dividend bit per cycle; a word passes accept, limit check, one remainder
// step per dividend bit, symbol load and result hold, and the next word is
// taken only after the result transaction. With password_length zero or no
// class enabled every word yields an error result, loaded in the check state
// and held until taken. Configuration writes are always taken and must
// only be issued while no word is in flight.
module random_symbol_picker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rsp_pkg::WORD_W-1:0]          s_tdata,   // [31:0] random_word
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [6:0] symbol, [7] zero
    output logic                                m_tlast,
    output logic [rsp_pkg::STATUS_W-1:0]        m_tuser,   // [1:0] status
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rsp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rsp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rsp_pkg::*;

    dp_cmd_t          cmd;
    dp_status_t       status;
    logic [SYM_W-1:0] symbol;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {1'b0, symbol};

    rsp_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    rsp_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .word_in       (s_tdata),
        .cfg_write     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .symbol        (symbol),
        .last          (m_tlast),
        .result_status (m_tuser)
    );

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for random_symbol_picker: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import rsp_pkg::*;

    localparam int DRAIN_CYCLES  = 48;     // longest word latency plus margin
    localparam int DRAIN_LIMIT   = 20000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int PRESSURE_PHASE = 5;

    // Indexes past the register list: writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_MID = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [SYM_W-1:0]    sym;
        logic                last;
        logic [STATUS_W-1:0] status;
    } pw_char_t;

    typedef enum logic [1:0] {
        EXP_CALC,    // expectation from the predictor
        EXP_NONE,    // word must be rejected
        EXP_TYPED    // expectation written into the table
    } exp_kind_t;

    typedef enum logic {
        ROW_CFG,
        ROW_WORD
    } row_op_t;

    typedef struct {
        row_op_t             op;
        logic [CFG_IDX_W-1:0] idx;
        logic [WORD_W-1:0]   val;
        exp_kind_t           ek;
        pw_char_t            typed;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [WORD_W-1:0]     s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    random_symbol_picker uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #12_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // Predictor state
    logic             en_lower, en_upper, en_digit, en_special;
    logic [LEN_W-1:0] pw_len;
    logic [LEN_W-1:0] chars_in_pw;
    string            picker_alphabet;

    pw_char_t         expected_chars[$];
    dir_row_t         dir_rows[$];
    logic [CFG_IDX_W-1:0]  cfg_idx_q[$];
    logic [CFG_DATA_W-1:0] cfg_dat_q[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int          err_count = 0;
    logic        hold_req_tog = 1'b0;
    logic        hold_ack_tog = 1'b0;
    int          hold_left = 0;

    function automatic string build_alphabet();
        string a;
        a = "";
        if (en_lower)   a = {a, "azertyuiopqsdfghjklmwxcvbn"};
        if (en_upper)   a = {a, "AZERTYUIOPQSDFGHJKLMWXCVBN"};
        if (en_digit)   a = {a, "1234567890"};
        if (en_special) a = {a, "[](){}.?!,:;/\\|-~#&=^$%*"};
        return a;
    endfunction

    function automatic logic [WORD_W-1:0] rejection_limit();
        logic [WORD_W-1:0] n;
        n = picker_alphabet.len();
        return WORD_MAX - (WORD_MAX % n);
    endfunction

    task automatic reset_picker();
        en_lower = 1'b1;
        en_upper = 1'b1;
        en_digit = 1'b1;
        en_special = 1'b0;
        pw_len = 10'd16;
        chars_in_pw = '0;
        picker_alphabet = build_alphabet();
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        case (idx)
            REG_LOWER:   en_lower = d[0];
            REG_UPPER:   en_upper = d[0];
            REG_DIGIT:   en_digit = d[0];
            REG_SPECIAL: en_special = d[0];
            REG_LENGTH:  pw_len = d[LEN_W-1:0];
            default: ;
        endcase
        picker_alphabet = build_alphabet();
    endtask

    // Step the predictor by one accepted word
    task automatic advance_picker(input logic [WORD_W-1:0] w, output bit emits,
                                  output pw_char_t c);
        logic [WORD_W-1:0] n;
        logic [LEN_W-1:0]  nxt;
        logic              is_last;
        int                pos;
        logic [7:0]        ch;
        emits = 1'b1;
        c = '0;
        if (pw_len == 0) begin
            chars_in_pw = '0;
            c = {7'd0, 1'b1, STATUS_LEN_ZERO};
        end else if (picker_alphabet.len() == 0) begin
            chars_in_pw = '0;
            c = {7'd0, 1'b1, STATUS_NO_CLASS};
        end else if (w >= rejection_limit()) begin
            emits = 1'b0;
        end else begin
            n = picker_alphabet.len();
            pos = int'(w % n);
            nxt = chars_in_pw + 1'b1;
            is_last = (nxt >= pw_len) || (nxt == 0);
            chars_in_pw = is_last ? '0 : nxt;
            ch = picker_alphabet[pos];
            c.sym = ch[SYM_W-1:0];
            c.last = is_last;
            c.status = STATUS_OK;
        end
    endtask

    task automatic expect_char(input pw_char_t c);
        expected_chars = {expected_chars, c};
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb_top: mismatch %s: got 0x%0h, want 0x%0h at %0t ns",
                 what, got, want, $time);
        err_count++;
    endtask

    // Scoreboard on the result stream
    always @(posedge aclk) begin
        pw_char_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch("unexpected result", {24'd0, m_tdata}, 32'd0);
            end else begin
                e = expected_chars.pop_front();
                if (m_tdata !== {1'b0, e.sym})
                    report_mismatch("symbol", {24'd0, m_tdata}, {25'd0, e.sym});
                if (m_tlast !== e.last)
                    report_mismatch("last", {31'd0, m_tlast}, {31'd0, e.last});
                if (m_tuser !== e.status)
                    report_mismatch("status", {30'd0, m_tuser}, {30'd0, e.status});
            end
        end
    end

    // Result-side ready: random stalls, plus a counted hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req_tog != hold_ack_tog) begin
            hold_ack_tog <= hold_req_tog;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_word(input logic [WORD_W-1:0] w, input exp_kind_t ek,
                             input pw_char_t typed);
        bit       emits;
        pw_char_t c;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata <= $urandom;
            repeat ($urandom_range(40, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        do @(posedge aclk); while (!s_tready);
        advance_picker(w, emits, c);
        case (ek)
            EXP_CALC:  if (emits) expect_char(c);
            EXP_TYPED: expect_char(typed);
            default: ;
        endcase
    endtask

    // Idle the input and let every outstanding result arrive
    task automatic drain_results();
        int k;
        s_tvalid <= 1'b0;
        for (k = 0; k < DRAIN_LIMIT && expected_chars.size() != 0; k++)
            @(posedge aclk);
        if (expected_chars.size() != 0)
            report_mismatch("results outstanding", expected_chars.size(), 32'd0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_idx_q = {cfg_idx_q, idx};
        cfg_dat_q = {cfg_dat_q, d};
    endtask

    task automatic load_regs();
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] d;
        drain_results();
        while (cfg_idx_q.size() != 0) begin
            idx = cfg_idx_q.pop_front();
            d = cfg_dat_q.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= d;
            do @(posedge aclk); while (!cfg_ready);
            set_reg(idx, d);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        dir_row_t r;
        r.op = ROW_CFG;
        r.idx = idx;
        r.val = {22'd0, d};
        r.ek = EXP_CALC;
        r.typed = '0;
        dir_rows = {dir_rows, r};
    endtask

    task automatic add_word(input logic [WORD_W-1:0] w, input exp_kind_t ek,
                            input pw_char_t typed);
        dir_row_t r;
        r.op = ROW_WORD;
        r.idx = '0;
        r.val = w;
        r.ek = ek;
        r.typed = typed;
        dir_rows = {dir_rows, r};
    endtask

    // Mostly uniform words, with a share aimed at the rejection boundary
    function automatic logic [WORD_W-1:0] next_random_word();
        int unsigned       r;
        logic [WORD_W-1:0] lim;
        r = $urandom_range(99);
        if (picker_alphabet.len() == 0 || pw_len == 0 || r < 70)
            return $urandom;
        lim = rejection_limit();
        if (r < 88)
            return lim - 32'd4 + $urandom_range(WORD_MAX - lim + 32'd4);
        if (r < 94)
            return WORD_MAX;
        return $urandom_range(2 * picker_alphabet.len());
    endfunction

    initial begin
        int          phase;
        int          total;
        int          n_items;
        logic [3:0]  en;
        logic [9:0]  len;
        int unsigned pick;

        reset_picker();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset alphabet: lower, upper, digits; 62 symbols, limit 0xFFFFFFFC
        add_word(32'h0000_0000, EXP_TYPED, {7'h61, 1'b0, STATUS_OK});
        add_word(32'd61,        EXP_TYPED, {7'h30, 1'b0, STATUS_OK});
        add_word(32'd26,        EXP_TYPED, {7'h41, 1'b0, STATUS_OK});
        add_word(32'hFFFF_FFFB, EXP_CALC,  '0);
        add_word(32'hFFFF_FFFC, EXP_NONE,  '0);
        add_word(32'hFFFF_FFFF, EXP_NONE,  '0);
        add_word(32'd62,        EXP_CALC,  '0);
        // Length zero wins over everything, even the all-ones word
        add_cfg(REG_LENGTH, 10'd0);
        add_word(32'h1234_5678, EXP_TYPED, {7'd0, 1'b1, STATUS_LEN_ZERO});
        add_word(32'hFFFF_FFFF, EXP_TYPED, {7'd0, 1'b1, STATUS_LEN_ZERO});
        // No class enabled; upper data bits must be ignored
        add_cfg(REG_LENGTH, 10'd5);
        add_cfg(REG_LOWER, 10'h3FE);
        add_cfg(REG_UPPER, 10'h2AA);
        add_cfg(REG_DIGIT, 10'h100);
        add_word(32'h0000_0000, EXP_TYPED, {7'd0, 1'b1, STATUS_NO_CLASS});
        add_word(32'hFFFF_FFFF, EXP_TYPED, {7'd0, 1'b1, STATUS_NO_CLASS});
        // Full alphabet of 86, limit 0xFFFFFFF0; stray indexes do nothing
        add_cfg(REG_LOWER, 10'h3FF);
        add_cfg(REG_UPPER, 10'h001);
        add_cfg(REG_DIGIT, 10'h201);
        add_cfg(REG_SPECIAL, 10'h3FF);
        add_cfg(REG_UNUSED_LO, 10'h000);
        add_cfg(REG_UNUSED_MID, 10'h155);
        add_cfg(REG_UNUSED_HI, 10'h3FF);
        add_word(32'd85,        EXP_TYPED, {7'h2A, 1'b0, STATUS_OK});
        add_word(32'hFFFF_FFF0, EXP_NONE,  '0);
        add_word(32'hFFFF_FFEF, EXP_CALC,  '0);
        add_word(32'h8000_0000, EXP_CALC,  '0);
        add_word(32'h7FFF_FFFF, EXP_CALC,  '0);
        add_word(32'hDEAD_BEEF, EXP_CALC,  '0);
        // Specials only
        add_cfg(REG_LOWER, 10'h3FE);
        add_cfg(REG_UPPER, 10'h000);
        add_cfg(REG_DIGIT, 10'h000);
        add_word(32'd13,        EXP_TYPED, {7'h5C, 1'b0, STATUS_OK});
        add_word(32'd47,        EXP_CALC,  '0);
        // Back to defaults, then shorten the password mid-way
        add_cfg(REG_LENGTH, 10'd16);
        add_cfg(REG_LOWER, 10'h001);
        add_cfg(REG_UPPER, 10'h001);
        add_cfg(REG_DIGIT, 10'h001);
        add_cfg(REG_SPECIAL, 10'h000);
        add_word(32'd100,       EXP_CALC,  '0);
        add_word(32'd200,       EXP_CALC,  '0);
        add_word(32'd300,       EXP_CALC,  '0);
        add_word(32'd400,       EXP_CALC,  '0);
        add_cfg(REG_LENGTH, 10'd2);
        add_word(32'd7,         EXP_CALC,  '0);
        add_word(32'd8,         EXP_CALC,  '0);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].op == ROW_CFG) begin
                queue_reg(dir_rows[i].idx, dir_rows[i].val[CFG_DATA_W-1:0]);
            end else begin
                if (cfg_idx_q.size() != 0) load_regs();
                send_word(dir_rows[i].val, dir_rows[i].ek, dir_rows[i].typed);
            end
        end

        phase = 0;
        total = 0;
        while (total < RANDOM_ITEMS) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            if (phase == PRESSURE_PHASE) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end

            en = 4'($urandom_range(15));
            pick = $urandom_range(99);
            if (pick < 5)       len = 10'd0;
            else if (pick < 10) len = 10'd1023;
            else if (pick < 15) len = 10'd1;
            else                len = 10'($urandom_range(24, 1));
            case (phase)
                0: begin en = 4'hF; len = 10'd1; end
                1: begin en = 4'h0; len = 10'($urandom_range(24, 1)); end
                2: begin en = 4'hF; len = 10'd1023; end
                3: len = 10'd0;
                default: ;
            endcase

            queue_reg(REG_LOWER,   (CFG_DATA_W'($urandom) & 10'h3FE) | {9'd0, en[0]});
            queue_reg(REG_UPPER,   (CFG_DATA_W'($urandom) & 10'h3FE) | {9'd0, en[1]});
            queue_reg(REG_DIGIT,   (CFG_DATA_W'($urandom) & 10'h3FE) | {9'd0, en[2]});
            queue_reg(REG_SPECIAL, (CFG_DATA_W'($urandom) & 10'h3FE) | {9'd0, en[3]});
            queue_reg(REG_LENGTH,  len);
            if ($urandom_range(3) == 0)
                queue_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)),
                          CFG_DATA_W'($urandom));
            load_regs();

            // Hold the sink off while words keep coming, so the input backs up
            if (phase == PRESSURE_PHASE) hold_req_tog = ~hold_req_tog;

            n_items = $urandom_range(85, 40);
            repeat (n_items) send_word(next_random_word(), EXP_CALC, '0);
            total += n_items;
            phase++;
        end

        drain_results();
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

FILE: files.f
rtl/rsp_pkg.sv
rtl/rsp_datapath.sv
rtl/rsp_controller.sv
rtl/random_symbol_picker.sv
verif/tb_top.sv
